// File: rtl/core/bse_pkg.sv
// Shared types, constants and lookup tables for the state-of-charge estimator.
package bse_pkg;

  localparam int OCV_POINTS = 13;
  localparam int SEG_W      = 4;
  localparam int SOC_W      = 27;

  localparam logic [SOC_W-1:0] SOC_FULL = 27'd100000000;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_CAPACITY    = 3'd0;
  localparam logic [2:0] REG_FULL_MV     = 3'd1;
  localparam logic [2:0] REG_EMPTY_MV    = 3'd2;
  localparam logic [2:0] REG_REST_MA     = 3'd3;
  localparam logic [2:0] REG_DONE_MA     = 3'd4;
  localparam logic [2:0] REG_POS_DISCHG  = 3'd5;

  // OCV table, descending voltage, SoC in micro-percent.
  localparam logic [15:0] OCV_MV [OCV_POINTS] = '{
    16'd29200, 16'd27200, 16'd26800, 16'd26640, 16'd26480, 16'd26320, 16'd26160,
    16'd26000, 16'd25760, 16'd25360, 16'd24240, 16'd22400, 16'd20500
  };
  localparam logic [SOC_W-1:0] OCV_MICRO [OCV_POINTS] = '{
    27'd100000000, 27'd95000000, 27'd90000000, 27'd80000000, 27'd70000000,
    27'd60000000, 27'd50000000, 27'd40000000, 27'd30000000, 27'd20000000,
    27'd10000000, 27'd5000000, 27'd0
  };

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_OCV, S_BLEND_GO, S_BLEND, S_COUNT,
    S_CENTI_GO, S_CENTI, S_REM_GO, S_REM, S_DONE
  } bse_state_t;

  typedef enum logic [1:0] {
    P_IDLE, P_MUL, P_DIV
  } bse_phase_t;

  // One arithmetic job: (x * y + addend) / divisor.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [63:0] addend;
    logic [31:0] divisor;
  } bse_op_t;

endpackage

// File: rtl/core/bse_if.sv
// Valid/ready channel interfaces for meter samples and estimator results.
interface bse_sample_if;
  logic               valid;
  logic               ready;
  logic [15:0]        voltage_mv;
  logic signed [19:0] current_ma;
  logic [31:0]        now_ms;
  logic               sample_valid;

  modport source (output valid, voltage_mv, current_ma, now_ms, sample_valid, input ready);
  modport sink   (input valid, voltage_mv, current_ma, now_ms, sample_valid, output ready);
endinterface

interface bse_result_if;
  logic        valid;
  logic        ready;
  logic [13:0] soc_centi_percent;
  logic        soc_known;
  logic [15:0] remaining_mah;

  modport source (output valid, soc_centi_percent, soc_known, remaining_mah, input ready);
  modport sink   (input valid, soc_centi_percent, soc_known, remaining_mah, output ready);
endinterface

// File: rtl/core/bse_arith.sv
// Bit-serial multiply-accumulate followed by a bit-serial restoring divide.
module bse_arith (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bse_pkg::bse_op_t op,
  output logic            done,
  output logic [63:0]     quotient
);
  import bse_pkg::*;

  bse_phase_t  phase, phase_next;
  logic [5:0]  cnt;
  logic [63:0] acc;
  logic [63:0] xs;
  logic [31:0] ys;
  logic [31:0] dv;
  logic [31:0] rem;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh   = {rem, acc[63]};
  assign fits     = rem_sh >= {1'b0, dv};
  assign quotient = acc;

  always_comb begin
    phase_next = phase;
    case (phase)
      P_IDLE: if (start) phase_next = P_MUL;
      P_MUL:  if (cnt == 6'd31) phase_next = P_DIV;
      P_DIV:  if (cnt == 6'd63) phase_next = P_IDLE;
      default: phase_next = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == P_DIV) && (cnt == 6'd63);
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      P_IDLE: begin
        if (start) begin
          acc <= op.addend;
          xs  <= {32'd0, op.x};
          ys  <= op.y;
          dv  <= op.divisor;
          cnt <= 6'd0;
        end
      end
      P_MUL: begin
        // add one shifted partial product per cycle
        if (ys[0]) acc <= acc + xs;
        xs  <= {xs[62:0], 1'b0};
        ys  <= {1'b0, ys[31:1]};
        rem <= 32'd0;
        cnt <= (cnt == 6'd31) ? 6'd0 : cnt + 6'd1;
      end
      P_DIV: begin
        // one quotient bit per cycle, shifted into the dividend register
        if (fits) rem <= 32'(rem_sh - {1'b0, dv});
        else      rem <= rem_sh[31:0];
        acc <= {acc[62:0], fits};
        cnt <= cnt + 6'd1;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/battery_soc_estimator.sv
// Top level of the battery state-of-charge estimator.
// Takes one meter sample per item and returns one result item. Charge is held in
// micro-percent; anchors apply in order: full charge (voltage at or above the full
// threshold with small current) sets 100%, empty voltage sets 0%, an unknown
// estimate is seeded from the OCV table, a resting battery blends 2% toward the
// OCV value, and otherwise current times elapsed time is counted and clamped.
// All products and quotients go through one shared bit-serial unit that first
// multiplies and then divides. An item runs zero to four jobs: the state update
// takes none for an invalid sample or an anchor, one for counting, for seeding
// between table points or for a rest blend beyond the table ends, two for a rest
// blend between table points, plus two for the reported percent and mAh once the
// estimate is known (none while unknown). One item is in work at a time; a
// finished result waits in an output register until taken.
module battery_soc_estimator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  bse_sample_if.sink  sample,
  bse_result_if.source result
);
  import bse_pkg::*;

  // Configuration registers
  logic [15:0] capacity_mah, full_voltage_mv, empty_voltage_mv;
  logic [15:0] rest_current_ma, charge_done_current_ma;
  logic        positive_is_discharge;

  // Estimator state
  logic [SOC_W-1:0] soc;
  logic             known;
  logic [31:0]      last_time;

  // Captured sample
  logic [15:0] v;
  logic [19:0] mag;
  logic        neg;
  logic [31:0] now;
  logic        s_valid;

  bse_state_t       state, state_next;
  logic [SEG_W-1:0] seg, seg_found;
  logic             blend_pend;
  logic [SOC_W-1:0] ocv_val;
  logic [13:0]      centi;
  logic [15:0]      rem_mah;

  logic        start;
  bse_op_t     op;
  logic        done;
  logic [63:0] q;

  logic             full_hit, empty_hit, ocv_hi, ocv_lo, lower;
  logic [SOC_W-1:0] ocv_edge, ocv_now, d_clamp, soc_count;
  logic [19:0]      raw_mag;
  logic [15:0]      cap_eff;
  logic [SOC_W:0]   soc_sum;
  logic             out_free;

  bse_arith u_arith (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (op),
    .done     (done),
    .quotient (q)
  );

  // Magnitude of the sample current; the most negative code keeps its size.
  assign raw_mag = sample.current_ma[19] ? 20'(-sample.current_ma) : sample.current_ma;

  assign full_hit  = (v >= full_voltage_mv) && (mag < {4'd0, charge_done_current_ma});
  assign empty_hit = v <= empty_voltage_mv;
  assign ocv_hi    = v >= OCV_MV[0];
  assign ocv_lo    = v <= OCV_MV[OCV_POINTS-1];
  assign ocv_edge  = ocv_hi ? SOC_FULL : '0;
  assign cap_eff   = (capacity_mah == 16'd0) ? 16'd1 : capacity_mah;
  assign lower     = (!neg && mag != 20'd0) ? positive_is_discharge : !positive_is_discharge;
  assign ocv_now   = OCV_MICRO[seg + SEG_W'(1)] + q[SOC_W-1:0];
  assign d_clamp   = (q > {37'd0, SOC_FULL}) ? SOC_FULL : q[SOC_W-1:0];
  assign soc_sum   = {1'b0, soc} + {1'b0, d_clamp};
  assign out_free  = !result.valid || result.ready;

  always_comb begin
    if (lower) soc_count = (d_clamp >= soc) ? '0 : soc - d_clamp;
    else       soc_count = (soc_sum > {1'b0, SOC_FULL}) ? SOC_FULL : soc_sum[SOC_W-1:0];
  end

  // First table segment whose lower voltage is at or below the sample.
  always_comb begin
    seg_found = '0;
    for (int k = OCV_POINTS - 2; k >= 0; k--) begin
      if (v >= OCV_MV[k+1]) seg_found = SEG_W'(k);
    end
  end

  // Next state and arithmetic job selection
  always_comb begin
    state_next = state;
    start      = 1'b0;
    op         = '0;
    case (state)
      S_IDLE: if (sample.valid) state_next = S_DECIDE;
      S_DECIDE: begin
        if (!s_valid || full_hit || empty_hit) begin
          state_next = S_CENTI_GO;
        end else if (!known || (mag < {4'd0, rest_current_ma})) begin
          if (ocv_hi || ocv_lo) begin
            state_next = known ? S_BLEND_GO : S_CENTI_GO;
          end else begin
            start      = 1'b1;
            op.x       = {16'd0, 16'(v - OCV_MV[seg_found + SEG_W'(1)])};
            op.y       = {5'd0, 27'(OCV_MICRO[seg_found]
                                    - OCV_MICRO[seg_found + SEG_W'(1)])};
            op.divisor = {16'd0, 16'(OCV_MV[seg_found] - OCV_MV[seg_found + SEG_W'(1)])};
            state_next = S_OCV;
          end
        end else begin
          start      = 1'b1;
          op.x       = {12'd0, mag} * 32'd1000;
          op.y       = now - last_time;
          op.divisor = {16'd0, cap_eff} * 32'd36;
          state_next = S_COUNT;
        end
      end
      S_OCV: if (done) state_next = blend_pend ? S_BLEND_GO : S_CENTI_GO;
      S_BLEND_GO: begin
        start      = 1'b1;
        op.x       = {5'd0, soc};
        op.y       = 32'd98;
        op.addend  = {36'd0, ocv_val, 1'b0};
        op.divisor = 32'd100;
        state_next = S_BLEND;
      end
      S_BLEND: if (done) state_next = S_CENTI_GO;
      S_COUNT: if (done) state_next = S_CENTI_GO;
      S_CENTI_GO: begin
        if (known) begin
          start      = 1'b1;
          op.x       = {5'd0, soc};
          op.y       = 32'd1;
          op.divisor = 32'd10000;
          state_next = S_CENTI;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CENTI: if (done) state_next = S_REM_GO;
      S_REM_GO: begin
        start      = 1'b1;
        op.x       = {16'd0, capacity_mah};
        op.y       = {5'd0, soc};
        op.divisor = 32'd100000000;
        state_next = S_REM;
      end
      S_REM: if (done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign sample.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state                  <= S_IDLE;
      capacity_mah           <= 16'd18000;
      full_voltage_mv        <= 16'd29200;
      empty_voltage_mv       <= 16'd20500;
      rest_current_ma        <= 16'd100;
      charge_done_current_ma <= 16'd200;
      positive_is_discharge  <= 1'b1;
      soc                    <= '0;
      known                  <= 1'b0;
      last_time              <= 32'd0;
      result.valid           <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY:   capacity_mah           <= cfg_data;
          REG_FULL_MV:    full_voltage_mv        <= cfg_data;
          REG_EMPTY_MV:   empty_voltage_mv       <= cfg_data;
          REG_REST_MA:    rest_current_ma        <= cfg_data;
          REG_DONE_MA:    charge_done_current_ma <= cfg_data;
          REG_POS_DISCHG: positive_is_discharge  <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_DECIDE: begin
          if (s_valid) begin
            last_time <= now;
            if (full_hit) begin
              soc   <= SOC_FULL;
              known <= 1'b1;
            end else if (empty_hit) begin
              soc   <= '0;
              known <= 1'b1;
            end else if (!known && (ocv_hi || ocv_lo)) begin
              soc   <= ocv_edge;
              known <= 1'b1;
            end
          end
        end
        S_OCV: begin
          if (done && !blend_pend) begin
            soc   <= ocv_now;
            known <= 1'b1;
          end
        end
        S_BLEND: if (done) soc <= q[SOC_W-1:0];
        S_COUNT: if (done) soc <= soc_count;
        default: ;
      endcase
      // hold the result until taken, then drop it
      if (state == S_DONE && out_free) result.valid <= 1'b1;
      else if (result.ready)           result.valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && sample.valid) begin
      v       <= sample.voltage_mv;
      mag     <= raw_mag;
      neg     <= sample.current_ma[19];
      now     <= sample.now_ms;
      s_valid <= sample.sample_valid;
    end
    if (state == S_DECIDE) begin
      seg        <= seg_found;
      blend_pend <= known;
      ocv_val    <= ocv_edge;
    end
    if (state == S_OCV && done) ocv_val <= ocv_now;
    if (state == S_CENTI_GO && !known) begin
      centi   <= 14'd0;
      rem_mah <= 16'd0;
    end
    if (state == S_CENTI && done) centi   <= q[13:0];
    if (state == S_REM && done)   rem_mah <= q[15:0];
    if (state == S_DONE && out_free) begin
      result.soc_centi_percent <= centi;
      result.soc_known         <= known;
      result.remaining_mah     <= rem_mah;
    end
  end

endmodule
